// ===== hw/rtl/sensor_sample_deadband_reporter_top_assert.svh =====
// Assertion macros for the deadband reporter checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SENSOR_SAMPLE_DEADBAND_REPORTER_TOP_ASSERT_SVH
`define SENSOR_SAMPLE_DEADBAND_REPORTER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SDR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/sdr_pkg.sv =====
// Shared types and constants for the sensor sample deadband reporter.
// No dependencies.
`default_nettype none

package sdr_pkg;

    localparam int unsigned ValW     = 32;
    localparam int unsigned StepW    = 31;
    localparam int unsigned CfgIdxW  = 3;
    localparam int unsigned CfgDataW = 32;
    localparam int unsigned InDataW  = 64;
    localparam int unsigned OutDataW = 96;
    localparam int unsigned OutUserW = 3;

    // Reset values (Q16.16 where signed values)
    localparam logic [StepW-1:0]       DeadbandRst   = 31'd0;
    localparam logic [StepW-1:0]       ReportStepRst = 31'd65536;
    localparam logic signed [ValW-1:0] LowerLimitRst = -32'sd655360000;
    localparam logic signed [ValW-1:0] UpperLimitRst = 32'sd655360000;
    localparam logic [StepW-1:0]       PeriodRst     = 31'd1000;
    localparam logic                   AutoReportRst = 1'b1;
    localparam logic signed [ValW-1:0] SeenMinRst    = 32'sd655360000;
    localparam logic signed [ValW-1:0] SeenMaxRst    = -32'sd655360000;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DEADBAND    = 3'd0,
        REG_REPORT_STEP = 3'd1,
        REG_LOWER_LIMIT = 3'd2,
        REG_UPPER_LIMIT = 3'd3,
        REG_PERIOD_MS   = 3'd4,
        REG_AUTO_REPORT = 3'd5
    } sdr_reg_idx_t;

    typedef struct packed {
        logic [StepW-1:0]       deadband;
        logic [StepW-1:0]       report_step;
        logic signed [ValW-1:0] lower_limit;
        logic signed [ValW-1:0] upper_limit;
        logic [StepW-1:0]       period_ms;
        logic                   auto_report;
    } sdr_cfg_t;

    typedef struct packed {
        logic                   sample_taken;
        logic                   value_changed;
        logic                   report_now;
        logic signed [ValW-1:0] held_value;
        logic signed [ValW-1:0] lowest_seen;
        logic signed [ValW-1:0] highest_seen;
    } sdr_result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sensor_sample_deadband_reporter_top.sv =====
// Top level of the sensor sample deadband reporter.
// Depends on sdr_pkg, sdr_cfg and sdr_core.
//
// Usage:
//   Slave stream (s_*): one transaction per timestamped sample,
//   tdata = {sample_value, now_ms}. Master stream (m_*): exactly one result
//   transaction per input, in order; tuser carries the three flags and tdata
//   the held value and the seen minimum and maximum.
//   Config channel (cfg_*): register index plus data, always ready. Write
//   only while no sample is in flight; indexes past auto_report are dropped.
// Pipeline: a sample passes the input register and then the result register
//   (two register stages) before it is presented on m_tvalid.
// Throughput: one sample per cycle while m_tready is high. The state update
//   (due check, deadband, clamp, report compare, min/max) is a single
//   combinational pass between the input register and the result register,
//   and each sample sees the state left by the one before it.
// Reset: rst_n clears both stages, loads the register reset values, zeroes
//   the held value and timers and sets the seen min/max to +10000/-10000.
// Stall: when m_tready is low a full result register holds; the input register
//   still takes one more sample, and s_tready drops only when both are full.
`default_nettype none

module sensor_sample_deadband_reporter_top
    import sdr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input samples
    input  wire logic                s_tvalid,
    output      logic                s_tready,
    input  wire logic [InDataW-1:0]  s_tdata,   // [31:0] now_ms, [63:32] sample_value
    // results
    output      logic                m_tvalid,
    input  wire logic                m_tready,
    output      logic [OutDataW-1:0] m_tdata,   // [31:0] held_value, [63:32] lowest_seen,
                                                // [95:64] highest_seen
    output      logic [OutUserW-1:0] m_tuser,   // [0] sample_taken, [1] value_changed,
                                                // [2] report_now
    // configuration writes
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    sdr_cfg_t    cfg;
    sdr_result_t result;

    logic                   in_valid_reg;
    logic [ValW-1:0]        in_now_reg;
    logic signed [ValW-1:0] in_sample_reg;
    logic                   out_valid_reg;
    sdr_result_t            out_res_reg;
    logic                   advance;

    // stage moves when the result slot is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    sdr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sdr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .now_ms       (in_now_reg),
        .sample_value (in_sample_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_now_reg    <= s_tdata[ValW-1:0];
            in_sample_reg <= $signed(s_tdata[2*ValW-1:ValW]);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.highest_seen, out_res_reg.lowest_seen,
                       out_res_reg.held_value};
    assign m_tuser  = {out_res_reg.report_now, out_res_reg.value_changed,
                       out_res_reg.sample_taken};

endmodule

`default_nettype wire

// ===== hw/rtl/sdr_cfg.sv =====
// Configuration register file for the deadband reporter.
// Depends on sdr_pkg.
`default_nettype none

module sdr_cfg
    import sdr_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output      logic                cfg_ready,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data,
    output      sdr_cfg_t            cfg
);

    sdr_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.deadband    <= DeadbandRst;
            cfg_reg.report_step <= ReportStepRst;
            cfg_reg.lower_limit <= LowerLimitRst;
            cfg_reg.upper_limit <= UpperLimitRst;
            cfg_reg.period_ms   <= PeriodRst;
            cfg_reg.auto_report <= AutoReportRst;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (sdr_reg_idx_t'(cfg_index))
                REG_DEADBAND:    cfg_reg.deadband    <= cfg_data[StepW-1:0];
                REG_REPORT_STEP: cfg_reg.report_step <= cfg_data[StepW-1:0];
                REG_LOWER_LIMIT: cfg_reg.lower_limit <= $signed(cfg_data[ValW-1:0]);
                REG_UPPER_LIMIT: cfg_reg.upper_limit <= $signed(cfg_data[ValW-1:0]);
                REG_PERIOD_MS:   cfg_reg.period_ms   <= cfg_data[StepW-1:0];
                REG_AUTO_REPORT: cfg_reg.auto_report <= cfg_data[0];
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdr_core.sv =====
// Per-sample update: due check, deadband, clamp, report and seen min/max.
// Holds the running state registers. Depends on sdr_pkg.
`default_nettype none

module sdr_core
    import sdr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   step,
    input  wire logic [ValW-1:0]        now_ms,
    input  wire logic signed [ValW-1:0] sample_value,
    input  wire sdr_cfg_t               cfg,
    output      sdr_result_t            result
);

    logic signed [ValW-1:0] current_value_reg, current_value_next;
    logic [ValW-1:0]        next_due_reg, next_due_next;
    logic [ValW-1:0]        last_sample_reg, last_sample_next;
    logic signed [ValW-1:0] min_seen_reg, min_seen_next;
    logic signed [ValW-1:0] max_seen_reg, max_seen_next;

    logic                   due;
    logic signed [ValW:0]   diff_in, diff_out;
    logic [ValW:0]          mag_in, mag_out;
    logic                   accept_change;
    logic signed [ValW-1:0] clamped;

    always_comb
    begin
        due = (now_ms >= next_due_reg) || (last_sample_reg > now_ms);

        // 33-bit differences cannot overflow
        diff_in = {current_value_reg[ValW-1], current_value_reg}
                - {sample_value[ValW-1], sample_value};
        mag_in  = diff_in[ValW] ? (~diff_in + 1'b1) : diff_in;
        accept_change = (mag_in >= {2'b00, cfg.deadband})
                     && (current_value_reg != sample_value);

        // upper check wins when the limits cross
        if (sample_value > cfg.upper_limit)
            clamped = cfg.upper_limit;
        else if (sample_value < cfg.lower_limit)
            clamped = cfg.lower_limit;
        else
            clamped = sample_value;

        diff_out = {current_value_reg[ValW-1], current_value_reg}
                 - {clamped[ValW-1], clamped};
        mag_out  = diff_out[ValW] ? (~diff_out + 1'b1) : diff_out;

        current_value_next = current_value_reg;
        next_due_next      = next_due_reg;
        last_sample_next   = last_sample_reg;
        min_seen_next      = min_seen_reg;
        max_seen_next      = max_seen_reg;

        result.sample_taken  = due;
        result.value_changed = due && accept_change;
        result.report_now    = due && accept_change && cfg.auto_report
                            && (mag_out >= {2'b00, cfg.report_step});

        if (due)
        begin
            last_sample_next = now_ms;
            if (accept_change)
            begin
                current_value_next = clamped;
                next_due_next      = now_ms + {1'b0, cfg.period_ms};
                if (clamped > max_seen_reg)
                    max_seen_next = clamped;
                if (clamped < min_seen_reg)
                    min_seen_next = clamped;
            end
        end

        result.held_value   = current_value_next;
        result.lowest_seen  = min_seen_next;
        result.highest_seen = max_seen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_value_reg <= '0;
            next_due_reg      <= '0;
            last_sample_reg   <= '0;
            min_seen_reg      <= SeenMinRst;
            max_seen_reg      <= SeenMaxRst;
        end
        else if (step)
        begin
            current_value_reg <= current_value_next;
            next_due_reg      <= next_due_next;
            last_sample_reg   <= last_sample_next;
            min_seen_reg      <= min_seen_next;
            max_seen_reg      <= max_seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sdr_checker.sv =====
// Port-level checker for the deadband reporter, bound to the top level.
// Depends on sdr_pkg and the assertion macro header.
`default_nettype none

`include "sensor_sample_deadband_reporter_top_assert.svh"

module sdr_checker
    import sdr_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                m_tvalid,
    input wire logic                m_tready,
    input wire logic [OutDataW-1:0] m_tdata,
    input wire logic [OutUserW-1:0] m_tuser
);

    `SDR_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")
    `SDR_ASSERT_NOW(a_change_needs_take, m_tvalid && m_tuser[1], m_tuser[0], "change without taken sample")
    `SDR_ASSERT_NOW(a_report_needs_change, m_tvalid && m_tuser[2], m_tuser[1], "report without change")
    `SDR_ASSERT_NOW(a_held_in_seen, m_tvalid && m_tuser[1], ($signed(m_tdata[63:32]) <= $signed(m_tdata[31:0])) && ($signed(m_tdata[31:0]) <= $signed(m_tdata[95:64])), "held value outside seen range")

endmodule

bind sensor_sample_deadband_reporter_top sdr_checker u_sdr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/sensor_sample_deadband_reporter_top_test.sv =====
// Self-checking testbench for sensor_sample_deadband_reporter_top.
// Drives timestamped samples and register writes; a scoreboard class predicts every result.
// Depends on sdr_pkg and the reporter RTL only.

module sensor_sample_deadband_reporter_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sdr_pkg::*;

    // Indexes beyond the register file; the block must drop these writes.
    localparam logic [CfgIdxW-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CfgIdxW-1:0] IDX_SPARE_HI = 3'd7;

    localparam int unsigned IDLE_PCT     = 34;
    localparam int unsigned HOLD_CYCLES  = 80;    // long receiver back-off
    localparam int unsigned STALL_LIMIT  = 4000;  // cycles with no transaction at all
    localparam int unsigned DRAIN_LIMIT  = 2000;
    localparam int unsigned DRAIN_EXTRA  = 4;     // two pipeline stages plus margin
    localparam int unsigned PHASES       = 10;
    localparam int unsigned PHASE_ITEMS  = 113;
    localparam int unsigned PRINT_CAP    = 30;

    // ------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the registers and of the state,
    // works out each result when a sample transaction is accepted and
    // compares it against the result transactions in order.
    // ------------------------------------------------------------------
    class deadband_tracker;
        // register copies
        logic [StepW-1:0]       band;
        logic [StepW-1:0]       step;
        logic signed [ValW-1:0] floor_lim;
        logic signed [ValW-1:0] ceil_lim;
        logic [StepW-1:0]       period;
        logic                   auto_on;
        // state copies
        logic signed [ValW-1:0] held;
        logic [ValW-1:0]        due_at;
        logic [ValW-1:0]        last_at;
        logic signed [ValW-1:0] seen_lo;
        logic signed [ValW-1:0] seen_hi;

        sdr_result_t expected_reports[$];

        int unsigned mismatches;
        int unsigned compared;
        int unsigned samples_in;
        int unsigned taken_cnt;
        int unsigned stored_cnt;
        int unsigned flagged_cnt;

        function new();
            band      = DeadbandRst;
            step      = ReportStepRst;
            floor_lim = LowerLimitRst;
            ceil_lim  = UpperLimitRst;
            period    = PeriodRst;
            auto_on   = AutoReportRst;
            held      = '0;
            due_at    = '0;
            last_at   = '0;
            seen_lo   = SeenMinRst;
            seen_hi   = SeenMaxRst;
            mismatches  = 0;
            compared    = 0;
            samples_in  = 0;
            taken_cnt   = 0;
            stored_cnt  = 0;
            flagged_cnt = 0;
        endfunction

        // |a - b| without overflow
        function logic [ValW:0] distance(logic signed [ValW-1:0] a, logic signed [ValW-1:0] b);
            logic signed [ValW+1:0] d;
            d = {{2{a[ValW-1]}}, a} - {{2{b[ValW-1]}}, b};
            if (d < 0)
                d = -d;
            return d[ValW:0];
        endfunction

        function void apply_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                REG_DEADBAND:    band      = data[StepW-1:0];
                REG_REPORT_STEP: step      = data[StepW-1:0];
                REG_LOWER_LIMIT: floor_lim = data;
                REG_UPPER_LIMIT: ceil_lim  = data;
                REG_PERIOD_MS:   period    = data[StepW-1:0];
                REG_AUTO_REPORT: auto_on   = data[0];
                default: ;
            endcase
        endfunction

        function void predict_sample(logic [ValW-1:0] stamp, logic signed [ValW-1:0] reading);
            sdr_result_t r;
            logic signed [ValW-1:0] v;
            r = '0;
            samples_in++;
            // due, or the timer has wrapped below the last sample time
            if (stamp >= due_at || last_at > stamp)
            begin
                r.sample_taken = 1'b1;
                taken_cnt++;
                if (distance(held, reading) >= {2'b00, band} && held != reading)
                begin
                    // upper check first, so crossed limits resolve toward the ceiling
                    if (reading > ceil_lim)
                        v = ceil_lim;
                    else if (reading < floor_lim)
                        v = floor_lim;
                    else
                        v = reading;
                    r.report_now    = auto_on && (distance(held, v) >= {2'b00, step});
                    r.value_changed = 1'b1;
                    held   = v;
                    due_at = stamp + {1'b0, period};
                    if (v > seen_hi)
                        seen_hi = v;
                    if (v < seen_lo)
                        seen_lo = v;
                    stored_cnt++;
                    if (r.report_now)
                        flagged_cnt++;
                end
                last_at = stamp;
            end
            r.held_value   = held;
            r.lowest_seen  = seen_lo;
            r.highest_seen = seen_hi;
            expected_reports = {expected_reports, r};
        endfunction

        task report_mismatch(string note);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("MISMATCH #%0d at %0t: %s", mismatches, $realtime, note);
        endtask

        task field_check(string label, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("result %0d %s: got 0x%08h, expected 0x%08h",
                                          compared, label, got, want));
        endtask

        task check_result(logic [OutUserW-1:0] flags, logic [OutDataW-1:0] word);
            sdr_result_t e;
            if (expected_reports.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing pending: tuser=%b tdata=0x%024h",
                                          flags, word));
                return;
            end
            e = expected_reports.pop_front();
            field_check("sample_taken",  32'(flags[0]), 32'(e.sample_taken));
            field_check("value_changed", 32'(flags[1]), 32'(e.value_changed));
            field_check("report_now",    32'(flags[2]), 32'(e.report_now));
            field_check("held_value",    word[31:0],    e.held_value);
            field_check("lowest_seen",   word[63:32],   e.lowest_seen);
            field_check("highest_seen",  word[95:64],   e.highest_seen);
            compared++;
        endtask

        task close_out();
            while (expected_reports.size() != 0)
            begin
                void'(expected_reports.pop_front());
                report_mismatch("result never arrived");
            end
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata;    // [31:0] now_ms, [63:32] sample_value
    logic                m_tvalid;
    logic                m_tready;
    logic [OutDataW-1:0] m_tdata;    // [31:0] held_value, [63:32] lowest_seen,
                                     // [95:64] highest_seen
    logic [OutUserW-1:0] m_tuser;    // [0] sample_taken, [1] value_changed, [2] report_now
    logic                cfg_valid;
    logic                cfg_ready;
    logic [CfgIdxW-1:0]  cfg_index;
    logic [CfgDataW-1:0] cfg_data;

    sensor_sample_deadband_reporter_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    deadband_tracker book;

    bit          gaps_on;        // random idling on both sides
    bit          hold_request;   // asks the result sink for a long back-off
    int unsigned settings_used;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Drivers. Everything is driven with NBAs right after a rising edge
    // and handshakes are judged on values sampled at that edge.
    // ------------------------------------------------------------------

    // One sample transaction; the prediction is made at acceptance, so the
    // caller always sees the state left by the previous sample.
    task automatic send_sample(input logic [ValW-1:0] stamp, input logic signed [ValW-1:0] reading);
        while (gaps_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {reading, stamp};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        book.predict_sample(stamp, reading);
    endtask

    // One register write; valid drops for a cycle so that back-to-back
    // writes never lower and raise it within the same step.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        book.apply_write(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Full register set; the unused upper bits carry junk to check masking,
    // and both spare indexes get a write that must change nothing.
    task automatic program_all(input logic [StepW-1:0] band, input logic [StepW-1:0] stp,
                               input logic [ValW-1:0] lo, input logic [ValW-1:0] hi,
                               input logic [StepW-1:0] per, input logic au);
        write_reg(REG_DEADBAND,    {1'($urandom), band});
        write_reg(REG_REPORT_STEP, {1'($urandom), stp});
        write_reg(REG_LOWER_LIMIT, lo);
        write_reg(REG_UPPER_LIMIT, hi);
        write_reg(REG_PERIOD_MS,   {1'($urandom), per});
        write_reg(REG_AUTO_REPORT, {31'($urandom), au});
        write_reg(IDX_SPARE_LO, $urandom);
        write_reg(IDX_SPARE_HI, $urandom);
        settings_used++;
    endtask

    // Stop offering and wait for every pending result, then let the
    // pipeline go quiet before anything else happens.
    task automatic settle();
        int unsigned waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (book.expected_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_EXTRA) @(posedge clk);
    endtask

    // Timestamp mostly at or just past the due time so that samples get
    // taken; the rest is not-due, repeated, wrapped or arbitrary.
    function automatic logic [ValW-1:0] pick_stamp();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 55)
            return book.due_at + 32'($urandom_range(3));
        else if (sel < 70)
            return book.due_at - 32'($urandom_range(1, 4));
        else if (sel < 78)
            return book.last_at;
        else if (sel < 86)
            return book.last_at - 32'($urandom_range(1, 1000));
        return $urandom;
    endfunction

    // Values around the deadband and report-step edges, equal to the held
    // value, around the limits, at the type extremes, or fully random.
    function automatic logic signed [ValW-1:0] pick_value();
        logic signed [63:0] base;
        logic signed [63:0] delta;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 30)
        begin
            case ($urandom_range(5))
                0: delta = {33'b0, book.band};
                1: delta = {33'b0, book.band} - 1;
                2: delta = {33'b0, book.band} + 1;
                3: delta = {33'b0, book.step};
                4: delta = {33'b0, book.step} - 1;
                default: delta = 64'($urandom_range(255));
            endcase
            base = {{32{book.held[ValW-1]}}, book.held};
            base = $urandom_range(1) ? base + delta : base - delta;
        end
        else if (sel < 38)
            return book.held;
        else if (sel < 55)
        begin
            base = $urandom_range(1) ? {{32{book.floor_lim[ValW-1]}}, book.floor_lim}
                                     : {{32{book.ceil_lim[ValW-1]}}, book.ceil_lim};
            base = base + 64'($urandom_range(8)) - 64'sd4;
        end
        else if (sel < 65)
        begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        else
            return $urandom;
        // saturate into the 32-bit range
        if (base > 64'sh7FFF_FFFF)
            base = 64'sh7FFF_FFFF;
        else if (base < -64'sh8000_0000)
            base = -64'sh8000_0000;
        return base[ValW-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Result sink: checks each result transaction and decides tready.
    // A hold request makes it back off for HOLD_CYCLES counted here,
    // which fills both pipeline stages and stalls s_tready.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                book.check_result(m_tuser, m_tdata);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog: too many cycles without any transaction means a hang.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transaction", quiet);
                $display("[sensor_sample_deadband_reporter_top] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int lim_a;
        int lim_b;
        book = new();
        gaps_on       = 1'b1;
        hold_request  = 1'b0;
        settings_used = 0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset register values.
        send_sample(32'd0, 32'sd0);                          // equal to held: taken, dropped
        send_sample(32'd0, 32'sd327680);                     // first change, reports
        send_sample(32'd500, -32'sd327680);                  // not due yet
        send_sample(book.due_at - 32'd1, 32'sd1);            // one short of due
        send_sample(book.due_at, 32'h7FFF_FFFF);             // clamped to ceiling
        send_sample(book.due_at, 32'h8000_0000);             // clamped to floor, full swing
        send_sample(book.due_at, book.held + 32'sh8000);     // change under the report step
        send_sample(book.due_at, book.held + 32'sd65536);    // exactly the report step
        send_sample(book.due_at, book.held + 32'sd65535);    // one under the step
        send_sample(book.due_at, book.held);                 // equal, deadband zero
        send_sample(book.last_at, 32'sd0);                   // same stamp as last
        send_sample(32'd3, -32'sd1);                         // timer wrapped below last
        send_sample(32'hFFFF_FF00, 32'sd65536000);           // due time wraps past zero
        send_sample(32'hFFFF_FF01, -32'sd65536000);          // so this one is due at once
        send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(32'h0000_0000, 32'h0000_0001);           // wrap back to zero
        send_sample(book.due_at, 32'sd655360000);            // exactly the ceiling
        send_sample(book.due_at, 32'sd655360001);            // clamps onto the held value
        send_sample(book.due_at, -32'sd655360001);           // just under the floor

        // Random part, one register setting per phase.
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            case (p)
                // widest limits, no deadband, period zero: 33-bit differences
                0: program_all(31'd0, 31'd1, 32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 1'b1);
                // deadband, report step and period at their top, limits +/-100, reporting off
                1: program_all(31'h7FFF_FFFF, 31'h7FFF_FFFF, -32'sd6553600, 32'sd6553600,
                               31'h7FFF_FFFF, 1'b0);
                // crossed limits, report step zero
                2: program_all(31'd1024, 31'd0, 32'sd65536000, -32'sd65536000, 31'd5, 1'b1);
                // floor equal to ceiling
                3: begin
                    lim_a = $urandom;
                    program_all(31'd0, 31'd0, lim_a, lim_a, 31'd1, 1'b1);
                end
                default: begin
                    lim_a = int'($urandom_range(262144000)) - 131072000;
                    lim_b = int'($urandom_range(262144000)) - 131072000;
                    if (lim_a > lim_b)
                    begin
                        lim_a = lim_a ^ lim_b;
                        lim_b = lim_a ^ lim_b;
                        lim_a = lim_a ^ lim_b;
                    end
                    program_all(31'($urandom_range(262144)), 31'($urandom_range(524288)),
                                lim_a, lim_b, 31'($urandom_range(40)), 1'($urandom));
                end
            endcase
            gaps_on = (p != 4);          // one long stretch at full rate
            if (p == 6)
                hold_request = 1'b1;     // back-pressure while samples keep coming
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_sample(pick_stamp(), pick_value());
        end

        settle();
        book.close_out();
        $display("Covered %0d samples over %0d register settings plus reset values:",
                 book.samples_in, settings_used);
        $display("  %0d taken, %0d stored, %0d flagged; %0d results compared, %0d mismatches",
                 book.taken_cnt, book.stored_cnt, book.flagged_cnt, book.compared,
                 book.mismatches);
        if (book.mismatches == 0)
            $display("[sensor_sample_deadband_reporter_top] OK");
        else
            $display("[sensor_sample_deadband_reporter_top] ERROR");
        $finish;
    end

endmodule
